// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the RTL files of the interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is held.
`define TLI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TLI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/tli_pkg.sv -----
// Package with the constants and transaction types of the table linear interpolator.
package tli_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W       = 16;
    localparam int VAL_W       = 18;
    localparam int SLOT_W      = 5;
    localparam int CFG_W       = 6;

    localparam logic [VAL_W-1:0] VALUE_MAX     = '1;
    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(32);

    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from the word address of the configuration port.
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_LOAD  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [SLOT_W-1:0] entry_slot;
        logic [KEY_W-1:0]  key_value;
        logic [VAL_W-1:0]  table_value;
    } t_tli_in;

    typedef struct packed {
        logic [VAL_W-1:0] interpolated_value;
        logic             clamped;
    } t_tli_out;

endpackage

// ----- rtl/core/table_linear_interpolator_unit.sv -----
// Top level of the table linear interpolator: table memory, search sequencer and serial divider.
//
// The input channel carries transactions of two kinds. A load writes one key and value into
// the table without a result. A query searches the first entries_in_use keys for the one
// nearest the query key, picks the bracketing pair of entries and returns the value
// interpolated between them, with clamped set at a table end. The time a query takes from
// acceptance until its result sits in the output register grows with n, the number of
// entries searched, and is set by the table memory, which gives one entry per cycle through
// a single read port, and by the restoring divider, which produces one quotient bit per cycle
// over 18 steps. Queries that end at a table end or on equal keys skip the sum and divide
// and finish sooner.
// The input stall is high while a query is in work, so one query is handled at a time. The
// next transaction can be taken in the cycle after the result is registered, so a new query
// is accepted only once the last one is through.
// Results wait in an output register; while the receiver stalls, loads are still taken, and
// a finished query holds in its last state until the output register is free.
// Reset sets entries_in_use to 32 and clears the sequencer and the output valid. The table
// memory is not cleared: an entry must be loaded before a query searches it.
// The configuration port is APB-style with one register, entries_in_use, at address 0.
`include "assert_macros.svh"

module table_linear_interpolator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  tli_pkg::t_tli_in                    i_in_data,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output tli_pkg::t_tli_out                   o_out_data,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tli_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [tli_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tli_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [ST_W-1:0] ST_SCAN  = 4'd1;
    localparam logic [ST_W-1:0] ST_FIN   = 4'd2;
    localparam logic [ST_W-1:0] ST_PICK  = 4'd3;
    localparam logic [ST_W-1:0] ST_RDHI  = 4'd4;
    localparam logic [ST_W-1:0] ST_GETHI = 4'd5;
    localparam logic [ST_W-1:0] ST_MUL   = 4'd6;
    localparam logic [ST_W-1:0] ST_SUM   = 4'd7;
    localparam logic [ST_W-1:0] ST_CHK   = 4'd8;
    localparam logic [ST_W-1:0] ST_DIV   = 4'd9;
    localparam logic [ST_W-1:0] ST_DONE  = 4'd10;

    localparam int KW = tli_pkg::KEY_W;
    localparam int VW = tli_pkg::VAL_W;
    localparam int IW = tli_pkg::IDX_W;
    localparam int NUM_W = 36;

    // Table memory.
    logic [KW-1:0] key_mem [tli_pkg::TABLE_DEPTH];
    logic [VW-1:0] val_mem [tli_pkg::TABLE_DEPTH];

    logic [ST_W-1:0]              r_state, n_state;
    logic [tli_pkg::CFG_W-1:0]    r_entries;
    logic [KW-1:0]                r_q;
    logic [IW-1:0]                r_addr;
    logic [IW-1:0]                rd_addr;
    logic [KW-1:0]                r_rd_key;
    logic [VW-1:0]                r_rd_val;
    logic                         r_rd_vld;
    logic [IW-1:0]                r_rd_idx;
    logic [KW-1:0]                r_best_dist;
    logic [IW-1:0]                r_best_idx;
    logic [KW-1:0]                r_best_key;
    logic [IW-1:0]                r_lo, r_hi;
    logic [KW-1:0]                r_kb, r_ka;
    logic [VW-1:0]                r_vb, r_va;
    logic signed [NUM_W-1:0]      r_p1, r_p2, r_num;
    logic                         r_dneg;
    logic [KW-1:0]                r_dabs;
    logic [KW-1:0]                r_rem;
    logic [VW-1:0]                r_shift;
    logic [tli_pkg::STEP_W-1:0]   r_step;
    logic [VW-1:0]                r_res;
    logic                         r_clamp;
    logic                         r_out_valid;
    tli_pkg::t_tli_out            r_out_data;

    logic                         in_accept;
    logic                         out_free;
    logic                         slot_ok;
    logic [tli_pkg::CNT_W-1:0]    n_active;
    logic [IW-1:0]                last_idx;
    logic [KW-1:0]                scan_dist;
    logic                         best_ge;
    logic [IW-1:0]                pick_lo, pick_hi;
    logic signed [KW:0]           key_diff;
    logic signed [KW:0]           q_diff;
    logic signed [VW:0]           val_diff;
    logic signed [NUM_W-1:0]      num_sum;
    logic [KW:0]                  div_trial;
    logic                         div_ge;
    logic                         cfg_write;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign slot_ok    = 32'(i_in_data.entry_slot) < 32'(tli_pkg::TABLE_DEPTH);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    always_comb begin
        if (paddr[2] == tli_pkg::REG_ENTRIES_IN_USE) begin
            prdata = tli_pkg::APB_DATA_W'(r_entries);
        end else begin
            prdata = '0;
        end
    end

    // A register value of zero searches one entry; values past the table depth search all.
    always_comb begin
        if (r_entries == '0) begin
            n_active = tli_pkg::CNT_W'(1);
        end else if (32'(r_entries) > 32'(tli_pkg::TABLE_DEPTH)) begin
            n_active = tli_pkg::CNT_W'(tli_pkg::TABLE_DEPTH);
        end else begin
            n_active = tli_pkg::CNT_W'(r_entries);
        end
    end
    assign last_idx = IW'(n_active - tli_pkg::CNT_W'(1));

    // Distance of the entry just read from the query key.
    assign scan_dist = (r_rd_key >= r_q) ? (r_rd_key - r_q) : (r_q - r_rd_key);

    // Bracketing pair: below the nearest entry when it lies at or above the query, else above.
    assign best_ge = (r_best_key >= r_q);
    always_comb begin
        if (best_ge) begin
            pick_hi = r_best_idx;
            pick_lo = (r_best_idx != '0) ? (r_best_idx - IW'(1)) : r_best_idx;
        end else begin
            pick_lo = r_best_idx;
            pick_hi = (r_best_idx != last_idx) ? (r_best_idx + IW'(1)) : r_best_idx;
        end
    end

    always_comb begin
        unique case (r_state)
            ST_PICK: rd_addr = pick_lo;
            ST_RDHI: rd_addr = r_hi;
            default: rd_addr = r_addr;
        endcase
    end

    assign key_diff = $signed({1'b0, r_ka}) - $signed({1'b0, r_kb});
    assign q_diff   = $signed({1'b0, r_q}) - $signed({1'b0, r_kb});
    assign val_diff = $signed({1'b0, r_va}) - $signed({1'b0, r_vb});
    assign num_sum  = r_p1 + r_p2;

    // One step of the restoring divider.
    assign div_trial = {r_rem, r_shift[VW-1]};
    assign div_ge    = (div_trial >= {1'b0, r_dabs});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_accept && i_in_data.cmd == tli_pkg::CMD_QUERY) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_addr == last_idx) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN:   n_state = ST_PICK;
            ST_PICK:  n_state = ST_RDHI;
            ST_RDHI:  n_state = ST_GETHI;
            ST_GETHI: n_state = ST_MUL;
            ST_MUL: begin
                if (r_lo == r_hi || key_diff == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_CHK;
            ST_CHK: begin
                if (r_num[NUM_W-1] || r_num[NUM_W-2:VW] >= {1'b0, r_dabs}) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_step == tli_pkg::STEP_W'(tli_pkg::DIV_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Table memory: written by loads, read one address per cycle with registered data.
    always_ff @(posedge i_clk) begin
        if (in_accept && i_in_data.cmd == tli_pkg::CMD_LOAD && slot_ok) begin
            key_mem[IW'(i_in_data.entry_slot)] <= i_in_data.key_value;
            val_mem[IW'(i_in_data.entry_slot)] <= i_in_data.table_value;
        end
        r_rd_key <= key_mem[rd_addr];
        r_rd_val <= val_mem[rd_addr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entries   <= tli_pkg::ENTRIES_RESET;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            if (cfg_write && paddr[2] == tli_pkg::REG_ENTRIES_IN_USE) begin
                r_entries <= pwdata[tli_pkg::CFG_W-1:0];
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_q    <= i_in_data.key_value;
            r_addr <= '0;
        end
        if (r_state == ST_SCAN && r_addr != last_idx) begin
            r_addr <= r_addr + IW'(1);
        end
        r_rd_idx <= r_addr;

        // Nearest-key search; the first entry always seeds it, later ties keep the lower index.
        if (r_rd_vld && (r_rd_idx == '0 || scan_dist < r_best_dist)) begin
            r_best_dist <= scan_dist;
            r_best_idx  <= r_rd_idx;
            r_best_key  <= r_rd_key;
        end

        if (r_state == ST_PICK) begin
            r_lo <= pick_lo;
            r_hi <= pick_hi;
        end
        if (r_state == ST_RDHI) begin
            r_kb <= r_rd_key;
            r_vb <= r_rd_val;
        end
        if (r_state == ST_GETHI) begin
            r_ka <= r_rd_key;
            r_va <= r_rd_val;
        end

        if (r_state == ST_MUL) begin
            r_res   <= r_vb;
            r_clamp <= (r_lo == r_hi);
            r_p1    <= NUM_W'($signed({1'b0, r_vb}) * key_diff);
            r_p2    <= NUM_W'(q_diff * val_diff);
            r_dneg  <= key_diff[KW];
            r_dabs  <= key_diff[KW] ? KW'(-key_diff) : key_diff[KW-1:0];
        end

        if (r_state == ST_SUM) begin
            r_num <= r_dneg ? -num_sum : num_sum;
        end

        if (r_state == ST_CHK) begin
            r_clamp <= 1'b0;
            r_rem   <= r_num[NUM_W-3:VW];
            r_shift <= r_num[VW-1:0];
            r_step  <= '0;
            if (r_num[NUM_W-1]) begin
                r_res <= '0;
            end else begin
                r_res <= tli_pkg::VALUE_MAX;
            end
        end

        if (r_state == ST_DIV) begin
            r_rem   <= div_ge ? KW'(div_trial - {1'b0, r_dabs}) : div_trial[KW-1:0];
            r_shift <= {r_shift[VW-2:0], div_ge};
            r_step  <= r_step + tli_pkg::STEP_W'(1);
            r_res   <= {r_shift[VW-2:0], div_ge};
        end

        if (r_state == ST_DONE && out_free) begin
            r_out_data.interpolated_value <= r_res;
            r_out_data.clamped            <= r_clamp;
        end
    end

    // A new result appears only when a finished query leaves its last state.
    `TLI_ASSERT(a_out_from_done, $rose(o_out_valid) |-> $past(r_state) == ST_DONE, "result without finished query")

    // The divider remainder stays below the divisor, so the quotient bits are exact.
    `TLI_ASSERT(a_div_rem, r_state == ST_DIV |-> r_rem < r_dabs, "divider remainder out of range")

    // The search never reads past the entries in use.
    `TLI_ASSERT(a_scan_range, r_state == ST_SCAN |-> 32'(r_addr) < 32'(n_active), "scan beyond entries in use")

    // The bracketing pair is one entry or two neighbors.
    `TLI_ASSERT(a_pair_adjacent, r_state == ST_RDHI |-> (r_hi == r_lo) || (r_hi == r_lo + IW'(1)), "pair not adjacent")

endmodule
